/* rtl/gpr_pkg.sv */
// Shared constants and types for the glob-to-regex translator.
`timescale 1ns / 1ps
package gpr_pkg;

    localparam logic [7:0] CH_STAR    = 8'h2A; // '*'
    localparam logic [7:0] CH_QUEST   = 8'h3F; // '?'
    localparam logic [7:0] CH_DOT     = 8'h2E; // '.'
    localparam logic [7:0] CH_LBRACK  = 8'h5B; // '['
    localparam logic [7:0] CH_RBRACK  = 8'h5D; // ']'
    localparam logic [7:0] CH_BANG    = 8'h21; // '!'
    localparam logic [7:0] CH_CARET   = 8'h5E; // '^'
    localparam logic [7:0] CH_BSLASH  = 8'h5C; // '\'
    localparam logic [7:0] CH_LPAREN  = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN  = 8'h29; // ')'
    localparam logic [7:0] CH_LBRACE  = 8'h7B; // '{'
    localparam logic [7:0] CH_RBRACE  = 8'h7D; // '}'
    localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
    localparam logic [7:0] CH_PIPE    = 8'h7C; // '|'
    localparam logic [7:0] CH_DOLLAR  = 8'h24; // '$'

    // Bracket tracking carried from one pattern byte to the next
    typedef struct packed {
        logic inside_class;
        logic class_just_opened;
    } t_class_state;

    // Translation of one pattern byte: one or two regex bytes
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
    } t_xlat_res;

endpackage

/* rtl/gpr_xlat.sv */
// Combinational translation of one glob byte into its regex run.
`timescale 1ns / 1ps
module gpr_xlat (
    input  logic [7:0]            i_pattern_byte,
    input  logic                  i_pattern_last,
    input  gpr_pkg::t_class_state i_state,
    output gpr_pkg::t_xlat_res    o_res,
    output gpr_pkg::t_class_state o_state
);
    import gpr_pkg::*;

    logic is_meta;

    assign is_meta = (i_pattern_byte == CH_LPAREN) || (i_pattern_byte == CH_RPAREN) ||
                     (i_pattern_byte == CH_LBRACE) || (i_pattern_byte == CH_RBRACE) ||
                     (i_pattern_byte == CH_PLUS)   || (i_pattern_byte == CH_PIPE)   ||
                     (i_pattern_byte == CH_BSLASH) || (i_pattern_byte == CH_CARET)  ||
                     (i_pattern_byte == CH_DOLLAR);

    always_comb begin
        o_res.byte0             = i_pattern_byte;
        o_res.byte1             = CH_RBRACK;
        o_res.two               = 1'b0;
        o_state.inside_class      = i_state.inside_class;
        o_state.class_just_opened = 1'b0;
        if (i_state.inside_class) begin
            if (i_pattern_byte == CH_RBRACK) begin
                o_state.inside_class = 1'b0;
            end else begin
                if (i_pattern_byte == CH_BANG && i_state.class_just_opened) begin
                    o_res.byte0 = CH_CARET;
                end
                // close an unterminated class at end of pattern
                o_res.two = i_pattern_last;
            end
        end else begin
            case (i_pattern_byte)
                CH_STAR: begin
                    o_res.byte0 = CH_DOT;
                    o_res.byte1 = CH_STAR;
                    o_res.two   = 1'b1;
                end
                CH_QUEST: begin
                    o_res.byte0 = CH_DOT;
                end
                CH_DOT: begin
                    o_res.byte0 = CH_BSLASH;
                    o_res.byte1 = CH_DOT;
                    o_res.two   = 1'b1;
                end
                CH_LBRACK: begin
                    if (i_pattern_last) begin
                        o_res.byte0 = CH_BSLASH;
                        o_res.byte1 = CH_LBRACK;
                        o_res.two   = 1'b1;
                    end else begin
                        o_state.inside_class      = 1'b1;
                        o_state.class_just_opened = 1'b1;
                    end
                end
                default: begin
                    if (is_meta) begin
                        o_res.byte0 = CH_BSLASH;
                        o_res.byte1 = i_pattern_byte;
                        o_res.two   = 1'b1;
                    end
                end
            endcase
        end
        if (i_pattern_last) begin
            o_state.inside_class      = 1'b0;
            o_state.class_just_opened = 1'b0;
        end
    end

endmodule

/* rtl/glob_pattern_to_regex_text_core.sv */
// Data path: each pattern byte is registered in the input stage, then translated into the output stage.
// Throughput: one pattern byte per cycle while the receiver is ready and each byte maps to one regex byte;
// a byte that maps to two holds the input while the single-byte output port sends both.
// Reset (i_rst_n low, synchronous): both stages empty, bracket state cleared.
// Top level of the glob-to-regex translator.
`timescale 1ns / 1ps
module glob_pattern_to_regex_text_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_pattern_byte,
    input  logic       i_pattern_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_regex_byte,
    output logic       o_run_last,
    output logic       o_regex_done
);
    import gpr_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_q_valid;
    logic [7:0]   r_q_byte0;
    logic [7:0]   r_q_byte1;
    logic         r_q_two;
    logic         r_q_last;
    t_class_state r_state;
    t_class_state n_state;
    t_xlat_res    xl_res;
    logic         q_load_ok;
    logic         move;
    logic         out_xfer;

    gpr_xlat u_xlat (
        .i_pattern_byte (r_in_byte),
        .i_pattern_last (r_in_last),
        .i_state        (r_state),
        .o_res          (xl_res),
        .o_state        (n_state)
    );

    assign out_xfer  = r_q_valid && i_ready;
    assign q_load_ok = !r_q_valid || (i_ready && !r_q_two);
    assign move      = r_in_valid && q_load_ok;
    assign o_ready   = !r_in_valid || q_load_ok;

    assign o_valid      = r_q_valid;
    assign o_regex_byte = r_q_byte0;
    assign o_run_last   = !r_q_two;
    assign o_regex_done = !r_q_two && r_q_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_q_valid  <= 1'b0;
            r_q_two    <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (move) begin
                r_q_valid <= 1'b1;
                r_q_two   <= xl_res.two;
                r_state   <= n_state;
            end else if (out_xfer) begin
                // advance to the second byte of the run, or drain
                if (r_q_two) begin
                    r_q_two <= 1'b0;
                end else begin
                    r_q_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_pattern_byte;
            r_in_last <= i_pattern_last;
        end
        if (move) begin
            r_q_byte0 <= xl_res.byte0;
            r_q_byte1 <= xl_res.byte1;
            r_q_last  <= r_in_last;
        end else if (out_xfer && r_q_two) begin
            r_q_byte0 <= r_q_byte1;
        end
    end

`ifndef ASSERT_OFF
    a_run_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_run_last) |=> (o_valid && o_run_last))
        else $error("second byte of a run not presented after first transfer");

    a_just_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.class_just_opened |-> r_state.inside_class)
        else $error("class marked just opened while outside a class");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input stalled with an empty input stage");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_last) |=> (r_state == '0))
        else $error("bracket state not cleared after the last pattern byte");
`endif

endmodule

/* tb/glob_pattern_to_regex_text_core_checker.sv */
// Checker for the glob-to-regex translator: predicts regex bytes and compares them.
`timescale 1ns / 1ps
module glob_pattern_to_regex_text_core_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_pattern_byte,
    input  logic       i_pattern_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_regex_byte,
    input  logic       i_run_last,
    input  logic       i_regex_done,
    output int         o_fail_count,
    output int         o_pending
);
    import gpr_pkg::*;

    typedef struct packed {
        logic [7:0] rx;
        logic       run_last;
        logic       done;
    } t_regex_beat;

    t_regex_beat regex_q[$];

    logic in_class;
    logic class_opened;

    function automatic logic needs_escape(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
               c == CH_PLUS || c == CH_PIPE || c == CH_BSLASH || c == CH_CARET ||
               c == CH_DOLLAR;
    endfunction

    // Append one expected beat at the tail of the queue.
    function automatic void queue_beat(input t_regex_beat beat);
        regex_q.insert(regex_q.size(), beat);
    endfunction

    // Translate one pattern byte and queue the regex bytes it stands for.
    task automatic predict_regex_run(input logic [7:0] c, input logic last);
        logic [7:0]  run [2];
        int          n;
        logic        first;
        t_regex_beat beat;
        first = class_opened;
        class_opened = 1'b0;
        n = 0;
        if (in_class) begin
            if (c == CH_RBRACK) begin
                run[n++] = CH_RBRACK;
                in_class = 1'b0;
            end else if (c == CH_BANG && first) begin
                run[n++] = CH_CARET;
            end else begin
                run[n++] = c;
            end
            // close a class left open at the end of the pattern
            if (last && in_class)
                run[n++] = CH_RBRACK;
        end else begin
            case (c)
                CH_STAR: begin
                    run[n++] = CH_DOT;
                    run[n++] = CH_STAR;
                end
                CH_QUEST: begin
                    run[n++] = CH_DOT;
                end
                CH_DOT: begin
                    run[n++] = CH_BSLASH;
                    run[n++] = CH_DOT;
                end
                CH_LBRACK: begin
                    if (last) begin
                        run[n++] = CH_BSLASH;
                        run[n++] = CH_LBRACK;
                    end else begin
                        run[n++] = CH_LBRACK;
                        in_class = 1'b1;
                        class_opened = 1'b1;
                    end
                end
                default: begin
                    if (needs_escape(c))
                        run[n++] = CH_BSLASH;
                    run[n++] = c;
                end
            endcase
        end
        for (int k = 0; k < n; k++) begin
            beat.rx = run[k];
            beat.run_last = (k == n - 1);
            beat.done = (k == n - 1) && last;
            queue_beat(beat);
        end
        if (last) begin
            in_class = 1'b0;
            class_opened = 1'b0;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        in_class = 1'b0;
        class_opened = 1'b0;
    end

    always @(posedge i_clk) begin
        t_regex_beat want;
        if (!i_rst_n) begin
            in_class = 1'b0;
            class_opened = 1'b0;
            regex_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_regex_run(i_pattern_byte, i_pattern_last);
            if (i_out_valid && i_out_ready) begin
                if (regex_q.size() == 0) begin
                    $error("unexpected regex byte transfer: regex_byte %h", i_regex_byte);
                    o_fail_count++;
                end else begin
                    want = regex_q.pop_front();
                    if (i_regex_byte !== want.rx) begin
                        $error("regex_byte: expected %h, actual %h", want.rx, i_regex_byte);
                        o_fail_count++;
                    end
                    if (i_run_last !== want.run_last) begin
                        $error("run_last: expected %b, actual %b", want.run_last, i_run_last);
                        o_fail_count++;
                    end
                    if (i_regex_done !== want.done) begin
                        $error("regex_done: expected %b, actual %b", want.done, i_regex_done);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = regex_q.size();
    end

endmodule

/* tb/glob_pattern_to_regex_text_core_tb.sv */
// Testbench top for the glob-to-regex translator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module glob_pattern_to_regex_text_core_tb;

    import gpr_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_pattern_byte = 8'h00;
    logic       i_pattern_last = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_regex_byte;
    logic       o_run_last;
    logic       o_regex_done;

    int fail_count;
    int pending;
    int sent_count = 0;
    int cycle_count = 0;
    logic calm = 1'b0;
    logic [7:0] glob_q[$];

    glob_pattern_to_regex_text_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pattern_byte (i_pattern_byte),
        .i_pattern_last (i_pattern_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_regex_byte   (o_regex_byte),
        .o_run_last     (o_run_last),
        .o_regex_done   (o_regex_done)
    );

    glob_pattern_to_regex_text_core_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_pattern_byte (i_pattern_byte),
        .i_pattern_last (i_pattern_last),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_regex_byte   (o_regex_byte),
        .i_run_last     (o_run_last),
        .i_regex_done   (o_regex_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL glob_pattern_to_regex_text_core");
            $finish;
        end
    end

    // Receiver stalls about a quarter of the time, except in the calm stretch.
    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        calm <= (sent_count >= 700) && (sent_count < 1000);
    end

    // Append one byte at the tail of the pattern buffer.
    function automatic void add_glob_byte(input logic [7:0] b);
        glob_q.insert(glob_q.size(), b);
    endfunction

    // Offer one pattern byte and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pattern_byte <= b;
        i_pattern_last <= last;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_glob_q();
        for (int k = 0; k < glob_q.size(); k++)
            send_byte(glob_q[k], k == glob_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        glob_q.delete();
        for (int k = 0; k < s.len(); k++)
            add_glob_byte(s[k]);
        send_glob_q();
    endtask

    // Hold off the sender until every expected regex byte has arrived.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_glob_byte();
        logic [7:0] specials [16];
        specials = '{CH_STAR, CH_QUEST, CH_DOT, CH_LBRACK, CH_RBRACK, CH_BANG, CH_CARET,
                     CH_BSLASH, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_PLUS,
                     CH_PIPE, CH_DOLLAR, CH_STAR};
        if ($urandom_range(0, 99) < 45)
            return specials[$urandom_range(0, 15)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly literals and bracket classes; the rest raw noise.
    task automatic build_pattern();
        int segs;
        int body;
        logic [7:0] b;
        glob_q.delete();
        if ($urandom_range(0, 99) < 70) begin
            segs = $urandom_range(1, 5);
            for (int s = 0; s < segs; s++) begin
                if ($urandom_range(0, 99) < 35) begin
                    add_glob_byte(CH_LBRACK);
                    if ($urandom_range(0, 1))
                        add_glob_byte(CH_BANG);
                    body = $urandom_range(0, 3);
                    for (int k = 0; k < body; k++) begin
                        b = pick_glob_byte();
                        if (b == CH_RBRACK)
                            b = CH_BANG;
                        add_glob_byte(b);
                    end
                    if ($urandom_range(0, 99) < 80)
                        add_glob_byte(CH_RBRACK);
                end else begin
                    add_glob_byte(pick_glob_byte());
                end
            end
        end else begin
            body = $urandom_range(1, 6);
            for (int k = 0; k < body; k++)
                add_glob_byte($urandom_range(0, 1) ? pick_glob_byte()
                                                   : 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int random_start;
        logic drained_mid;
        drained_mid = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("*?.");
        send_text("[");
        send_text("[]");
        send_text("[!a]");
        send_text("[a!");
        send_text("[!");
        send_text("(){}+|\\^$");
        glob_q.delete();
        add_glob_byte(8'h00);
        add_glob_byte(8'hFF);
        send_glob_q();
        drain();

        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            build_pattern();
            send_glob_q();
            if (!drained_mid && sent_count >= 1200) begin
                drain();
                drained_mid = 1'b1;
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS glob_pattern_to_regex_text_core");
        else
            $display("FAIL glob_pattern_to_regex_text_core");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gpr_pkg.sv
rtl/gpr_xlat.sv
rtl/glob_pattern_to_regex_text_core.sv
tb/glob_pattern_to_regex_text_core_checker.sv
tb/glob_pattern_to_regex_text_core_tb.sv
